// ----- src/rud_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rud_pkg
// Shared types for the restoring unsigned divider pipeline.
// ----------------------------------------------------------------------------
package rud_pkg;

    // Control bits that travel down the pipeline with each division
    typedef struct packed {
        logic valid;     // stage holds a live division
        logic div_zero;  // divisor of this division was zero
    } t_ctrl;

    localparam t_ctrl CTRL_IDLE = '{valid: 1'b0, div_zero: 1'b0};

endpackage : rud_pkg
`default_nettype wire

// ----- src/restoring_unsigned_divider_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// restoring_unsigned_divider_core
// Fully pipelined WIDTH-bit unsigned restoring divider with zero detect.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_dividend and i_divisor and raise start. The
//   transfer happens on a rising edge with start high and busy low. busy is
//   always low here: every stage advances every cycle, so a new division
//   may be issued on every clock.
//   Result channel: o_done is high for exactly one cycle with o_quotient,
//   o_remainder and o_divide_by_zero valid; the transfer completes at the
//   edge ending that cycle. The receiver cannot stall, so nothing backs up.
//   One register stage per quotient bit (WIDTH bits, 32 by default).
//   Throughput: one division per cycle. Each stage holds one WIDTH+1 bit
//   trial subtract, which sets the clock.
//   Divide by zero: the stages naturally produce an all-ones quotient and
//   the dividend as remainder; the flag rides along with the data.
//   Reset (i_rst_n low, synchronous) clears every stage's valid bit, so any
//   division in flight is dropped and no strobe follows.
// ----------------------------------------------------------------------------
module restoring_unsigned_divider_core #(
    parameter int WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [WIDTH-1:0]  i_dividend,
    input  wire logic [WIDTH-1:0]  i_divisor,
    output logic                   o_done,
    output logic      [WIDTH-1:0]  o_quotient,
    output logic      [WIDTH-1:0]  o_remainder,
    output logic                   o_divide_by_zero
);

    // Stage k input is index k; index WIDTH is the pipeline output.
    rud_pkg::t_ctrl   w_ctrl [0:WIDTH];
    logic [WIDTH-1:0] w_rem  [0:WIDTH];
    logic [WIDTH-1:0] w_quo  [0:WIDTH];
    logic [WIDTH-1:0] w_div  [0:WIDTH];

    // pipeline never holds off a command
    assign busy = 1'b0;

    // Entry: remainder starts at zero, the dividend sits in the quotient slot
    // and is shifted into the remainder one bit per round.
    // Control word packs {valid, div_zero}.
    assign w_ctrl[0] = {start & ~busy, (i_divisor == '0)};
    assign w_rem[0]  = '0;
    assign w_quo[0]  = i_dividend;
    assign w_div[0]  = i_divisor;

    for (genvar k = 0; k < WIDTH; k++) begin : g_stage
        rud_stage #(
            .WIDTH (WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[k]),
            .i_rem   (w_rem[k]),
            .i_quo   (w_quo[k]),
            .i_div   (w_div[k]),
            .o_ctrl  (w_ctrl[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_quo   (w_quo[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    // Last stage registers drive the result ports directly.
    assign o_done           = w_ctrl[WIDTH].valid;
    assign o_divide_by_zero = w_ctrl[WIDTH].div_zero;
    assign o_quotient       = w_quo[WIDTH];
    assign o_remainder      = w_rem[WIDTH];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a result strobe always traces back to a matching earlier command
    a_done_has_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, WIDTH))
        else $error("result strobe without a matching command");

    // a real division leaves a remainder below its divisor
    a_rem_below_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_divide_by_zero) |-> (o_remainder < w_div[WIDTH]))
        else $error("remainder not below divisor");

    // divide by zero gives an all-ones quotient
    a_dbz_quotient : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_divide_by_zero) |-> (o_quotient == {WIDTH{1'b1}}))
        else $error("divide by zero quotient not all ones");

    // divide by zero hands back the dividend as remainder
    a_dbz_remainder : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_divide_by_zero) |-> (o_remainder == $past(i_dividend, WIDTH)))
        else $error("divide by zero remainder differs from dividend");

endmodule : restoring_unsigned_divider_core
`default_nettype wire

// ----- src/rud_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rud_stage
// One registered restoring-division round: shift, trial subtract, restore.
// ----------------------------------------------------------------------------
module rud_stage #(
    parameter int WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rud_pkg::t_ctrl    i_ctrl,
    input  wire logic [WIDTH-1:0]  i_rem,
    input  wire logic [WIDTH-1:0]  i_quo,
    input  wire logic [WIDTH-1:0]  i_div,
    output rud_pkg::t_ctrl         o_ctrl,
    output logic      [WIDTH-1:0]  o_rem,
    output logic      [WIDTH-1:0]  o_quo,
    output logic      [WIDTH-1:0]  o_div
);

    rud_pkg::t_ctrl   r_ctrl;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_div;

    logic [WIDTH:0]   w_shift;   // remainder shifted left, one bit wider
    logic [WIDTH:0]   w_diff;

    always_comb begin
        w_shift = {i_rem, i_quo[WIDTH-1]};
        w_diff  = w_shift - {1'b0, i_div};
        // no borrow out of the wide subtract: keep difference, set quotient bit
        if (!w_diff[WIDTH]) begin
            n_rem = w_diff[WIDTH-1:0];
            n_quo = {i_quo[WIDTH-2:0], 1'b1};
        end else begin
            n_rem = w_shift[WIDTH-1:0];
            n_quo = {i_quo[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= rud_pkg::CTRL_IDLE;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= i_div;
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_div  = r_div;

endmodule : rud_stage
`default_nettype wire
